### hdl/page_translate_clock_replace_unit_macros.svh
// Assertion helpers for the page translate unit.
// Both expect clk and rst_n in scope and are disabled while reset is low.
`ifndef PAGE_TRANSLATE_CLOCK_REPLACE_UNIT_MACROS_SVH
`define PAGE_TRANSLATE_CLOCK_REPLACE_UNIT_MACROS_SVH

// Same-cycle implication
`define PTCR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define PTCR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ptcr_pkg.sv
package ptcr_pkg;

  // Default geometry
  localparam int DEF_VADDR_BITS  = 16;
  localparam int DEF_PADDR_BITS  = 14;
  localparam int DEF_OFFSET_BITS = 8;

  // Fixed port field widths
  localparam int FRAME_IN_W  = 6;
  localparam int VADDR_IN_W  = 16;
  localparam int STATUS_W    = 3;
  localparam int PADDR_OUT_W = 14;

  // Operation codes
  localparam logic OP_LOAD      = 1'b0;
  localparam logic OP_TRANSLATE = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_LOADED = 3'd0,
    STAT_HIT    = 3'd1,
    STAT_FAULT  = 3'd2,
    STAT_SEGV   = 3'd3,
    STAT_EMPTY  = 3'd4
  } status_t;

endpackage

### hdl/page_translate_clock_replace_unit.sv
// Page table translation with clock (second-chance) frame replacement. One beat in gives one
// beat out. A load beat writes the next page-table entry in index order and, if it is valid
// and permitted and room is left, appends it to the resident-frame table. A translate beat
// reads the page table and answers segfault, empty or a non-resident hit from that read; a
// hit on a resident page adds a read-modify-write of the frame use bit. A page fault runs
// the clock hand one frame per cycle through the frame table, clearing the use bit of each
// frame it passes over (at most the resident count) until one has the bit clear, and maps
// the faulting page to that frame. The block takes no new beat while one is in work;
// a finished result waits in the output register and the next beat can start meanwhile.
// Both tables are memories with one write port and one registered read port; no clearing
// pass is needed, since page-table entries at or above the load count read as zero.
`include "page_translate_clock_replace_unit_macros.svh"

module page_translate_clock_replace_unit #(
  parameter int VADDR_BITS  = ptcr_pkg::DEF_VADDR_BITS,
  parameter int PADDR_BITS  = ptcr_pkg::DEF_PADDR_BITS,
  parameter int OFFSET_BITS = ptcr_pkg::DEF_OFFSET_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_operation,
  input  logic                               in_entry_valid,
  input  logic                               in_entry_perm,
  input  logic [ptcr_pkg::FRAME_IN_W-1:0]    in_entry_frame,
  input  logic                               in_entry_use,
  input  logic [ptcr_pkg::VADDR_IN_W-1:0]    in_virtual_address,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ptcr_pkg::STATUS_W-1:0]      out_status,
  output logic [ptcr_pkg::PADDR_OUT_W-1:0]   out_physical_address
);
  import ptcr_pkg::*;

  localparam int VPN_W    = VADDR_BITS - OFFSET_BITS;
  localparam int PFN_W    = PADDR_BITS - OFFSET_BITS;
  localparam int VPAGES   = 1 << VPN_W;
  localparam int PPAGES   = 1 << PFN_W;
  localparam logic [VPN_W:0] LOAD_END = (VPN_W+1)'(VPAGES);
  localparam logic [PFN_W:0] CNT_FULL = (PFN_W+1)'(PPAGES);

  // page-table entry: resident/slot point back into the frame table
  typedef struct packed {
    logic             valid;
    logic             perm;
    logic             resident;
    logic [PFN_W-1:0] slot;
    logic [PFN_W-1:0] frame;
  } pte_t;

  // frame-table entry
  typedef struct packed {
    logic [VPN_W-1:0] vpage;
    logic [PFN_W-1:0] frame;
    logic             used;
  } fte_t;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PT_RD  = 6'b000010,
    S_HIT_WR = 6'b000100,
    S_SW_CHK = 6'b001000,
    S_CLAIM  = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  // control state
  state_t           state_r, state_nxt;
  logic [VPN_W:0]   load_idx_r, load_idx_nxt;
  logic [PFN_W:0]   count_r, count_nxt;
  logic [PFN_W-1:0] hand_r, hand_nxt;
  logic             out_valid_r, out_valid_nxt;

  // working payload
  logic [VPN_W-1:0]       idx_r, idx_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  logic [PFN_W-1:0]       slot_r, slot_nxt;
  logic [PFN_W-1:0]       frame_r, frame_nxt;
  status_t                res_status_r, res_status_nxt;
  logic [PADDR_OUT_W-1:0] res_pa_r, res_pa_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [PADDR_OUT_W-1:0] out_pa_r, out_pa_nxt;

  // memory ports
  pte_t             pt_mem [VPAGES];
  pte_t             pt_rdata_r;
  logic             pt_we;
  logic [VPN_W-1:0] pt_waddr, pt_raddr;
  pte_t             pt_wdata;

  fte_t             ft_mem [PPAGES];
  fte_t             ft_rdata_r;
  logic             ft_we;
  logic [PFN_W-1:0] ft_waddr, ft_raddr;
  fte_t             ft_wdata;

  // input field extraction
  logic [31:0]            va_w, fr_w;
  logic [VPN_W-1:0]       in_idx;
  logic [OFFSET_BITS-1:0] in_off;
  logic [PFN_W-1:0]       in_frame;

  assign va_w     = 32'(in_virtual_address);
  assign fr_w     = 32'(in_entry_frame);
  assign in_idx   = va_w[VADDR_BITS-1:OFFSET_BITS];
  assign in_off   = va_w[OFFSET_BITS-1:0];
  assign in_frame = fr_w[PFN_W-1:0];

  // looked-up entry, zero above the load count
  pte_t pt_ent;
  assign pt_ent = ({1'b0, idx_r} < load_idx_r) ? pt_rdata_r : '0;

  // clock hand arithmetic: increment with wrap, and start position, both bounded by the resident count
  logic [PFN_W:0]   hand_ext, hand_inc;
  logic [PFN_W-1:0] hand_wrap, hand_start;
  assign hand_ext   = {1'b0, hand_r};
  assign hand_inc   = hand_ext + 1'b1;
  assign hand_wrap  = (hand_inc >= count_r) ? '0 : hand_inc[PFN_W-1:0];
  assign hand_start = (hand_ext >= count_r) ? '0 : hand_r;

  // physical address: frame concatenated with offset
  logic [PFN_W-1:0]      pa_frame;
  logic [PADDR_BITS-1:0] pa_full;
  logic [63:0]           pa_w;
  assign pa_frame = (state_r == S_SW_CHK) ? ft_rdata_r.frame : pt_ent.frame;
  assign pa_full  = {pa_frame, off_r};
  assign pa_w     = 64'(pa_full);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    load_idx_nxt   = load_idx_r;
    count_nxt      = count_r;
    hand_nxt       = hand_r;
    idx_nxt        = idx_r;
    off_nxt        = off_r;
    slot_nxt       = slot_r;
    frame_nxt      = frame_r;
    res_status_nxt = res_status_r;
    res_pa_nxt     = res_pa_r;
    pt_we          = 1'b0;
    pt_waddr       = load_idx_r[VPN_W-1:0];
    pt_wdata       = '0;
    pt_raddr       = in_idx;
    ft_we          = 1'b0;
    ft_waddr       = hand_r;
    ft_wdata       = '0;
    ft_raddr       = hand_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          idx_nxt = in_idx;
          off_nxt = in_off;
          if (in_operation == OP_LOAD) begin
            res_status_nxt = STAT_LOADED;
            res_pa_nxt     = '0;
            state_nxt      = S_DONE;
            if (load_idx_r < LOAD_END) begin
              pt_we             = 1'b1;
              pt_wdata.valid    = in_entry_valid;
              pt_wdata.perm     = in_entry_perm;
              pt_wdata.frame    = in_frame;
              pt_wdata.slot     = count_r[PFN_W-1:0];
              load_idx_nxt      = load_idx_r + 1'b1;
              // append to resident frames while room is left
              if (in_entry_valid && in_entry_perm && count_r < CNT_FULL) begin
                pt_wdata.resident = 1'b1;
                ft_we             = 1'b1;
                ft_waddr          = count_r[PFN_W-1:0];
                ft_wdata.vpage    = load_idx_r[VPN_W-1:0];
                ft_wdata.frame    = in_frame;
                ft_wdata.used     = in_entry_use;
                count_nxt         = count_r + 1'b1;
              end
            end
          end else begin
            state_nxt = S_PT_RD;
          end
        end
      end

      S_PT_RD: begin
        res_pa_nxt = '0;
        state_nxt  = S_DONE;
        if (!pt_ent.perm) begin
          res_status_nxt = STAT_SEGV;
        end else if (pt_ent.valid) begin
          res_status_nxt = STAT_HIT;
          res_pa_nxt     = pa_w[PADDR_OUT_W-1:0];
          if (pt_ent.resident) begin
            ft_raddr  = pt_ent.slot;
            slot_nxt  = pt_ent.slot;
            state_nxt = S_HIT_WR;
          end
        end else if (count_r == '0) begin
          res_status_nxt = STAT_EMPTY;
        end else begin
          res_status_nxt = STAT_FAULT;
          hand_nxt       = hand_start;
          ft_raddr       = hand_start;
          state_nxt      = S_SW_CHK;
        end
      end

      // set the use bit of the resident frame
      S_HIT_WR: begin
        ft_we         = 1'b1;
        ft_waddr      = slot_r;
        ft_wdata      = ft_rdata_r;
        ft_wdata.used = 1'b1;
        state_nxt     = S_DONE;
      end

      // one clock-hand step per cycle
      S_SW_CHK: begin
        ft_we    = 1'b1;
        ft_waddr = hand_r;
        hand_nxt = hand_wrap;
        ft_raddr = hand_wrap;
        if (!ft_rdata_r.used) begin
          // evict: old page loses its mapping, frame goes to faulting page
          pt_we          = 1'b1;
          pt_waddr       = ft_rdata_r.vpage;
          pt_wdata.perm  = 1'b1;
          pt_wdata.frame = ft_rdata_r.frame;
          ft_wdata.vpage = idx_r;
          ft_wdata.frame = ft_rdata_r.frame;
          ft_wdata.used  = 1'b1;
          slot_nxt       = hand_r;
          frame_nxt      = ft_rdata_r.frame;
          res_pa_nxt     = pa_w[PADDR_OUT_W-1:0];
          state_nxt      = S_CLAIM;
        end else begin
          ft_wdata      = ft_rdata_r;
          ft_wdata.used = 1'b0;
        end
      end

      // map the faulting page after the old one is invalidated
      S_CLAIM: begin
        pt_we             = 1'b1;
        pt_waddr          = idx_r;
        pt_wdata.valid    = 1'b1;
        pt_wdata.perm     = 1'b1;
        pt_wdata.resident = 1'b1;
        pt_wdata.slot     = slot_r;
        pt_wdata.frame    = frame_r;
        state_nxt         = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_pa_nxt     = out_pa_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_pa_nxt     = res_pa_r;
    end
  end

  assign in_stall             = (state_r != S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_physical_address = out_pa_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      load_idx_r  <= '0;
      count_r     <= '0;
      hand_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_idx_r  <= load_idx_nxt;
      count_r     <= count_nxt;
      hand_r      <= hand_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    off_r        <= off_nxt;
    slot_r       <= slot_nxt;
    frame_r      <= frame_nxt;
    res_status_r <= res_status_nxt;
    res_pa_r     <= res_pa_nxt;
    out_status_r <= out_status_nxt;
    out_pa_r     <= out_pa_nxt;
  end

  // page table memory, write-first on address match
  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[pt_waddr] <= pt_wdata;
    end
    if (pt_we && pt_waddr == pt_raddr) begin
      pt_rdata_r <= pt_wdata;
    end else begin
      pt_rdata_r <= pt_mem[pt_raddr];
    end
  end

  // frame table memory, write-first so a one-frame sweep sees its own clear
  always_ff @(posedge clk) begin
    if (ft_we) begin
      ft_mem[ft_waddr] <= ft_wdata;
    end
    if (ft_we && ft_waddr == ft_raddr) begin
      ft_rdata_r <= ft_wdata;
    end else begin
      ft_rdata_r <= ft_mem[ft_raddr];
    end
  end

  // checks
  `PTCR_ASSERT_IMP(a_hand_in_range, state_r == S_SW_CHK, hand_ext < count_r, "hand past resident frames")
  `PTCR_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_FULL, "resident count over table depth")
  `PTCR_ASSERT_NXT(a_done_delivers, state_r == S_DONE && !out_valid_r, out_valid_r, "result lost")
  `PTCR_ASSERT_NXT(a_load_short, state_r == S_IDLE && in_valid && in_operation == OP_LOAD, state_r == S_DONE, "load not finished in one step")

endmodule
